// File: rtl/heartbeat_sequence_monitor_macros.svh
// Assertion macros for the heartbeat sequence monitor.
// Used by the front end and engine; no other dependencies.
`ifndef HEARTBEAT_SEQUENCE_MONITOR_MACROS_SVH
`define HEARTBEAT_SEQUENCE_MONITOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HSM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HSM_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define HSM_ASSERT(name, prop, msg)
`define HSM_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// File: rtl/hsm_pkg.sv
// Shared types, codes and helpers for the heartbeat sequence monitor.
// No dependencies.
`timescale 1ns / 1ps
package hsm_pkg;

  localparam int MAX_TRACKED = 16;
  localparam int IDX_W       = $clog2(MAX_TRACKED);
  localparam int CNT_W       = $clog2(MAX_TRACKED + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QLVL_W      = 2;
  localparam logic [7:0] SEQ_WRAP_LIMIT = 8'd250;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_TICK = 2'd1,
    OP_REQ  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_RX,
    CMD_RX_IGN,
    CMD_TICK,
    CMD_REQ,
    CMD_REQ_IGN
  } cmd_kind_e;

  typedef enum logic [2:0] {
    EV_RX      = 3'd0,
    EV_TX      = 3'd1,
    EV_TIMEOUT = 3'd2,
    EV_REPLY   = 3'd3,
    EV_DONE    = 3'd4
  } event_e;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_NONSTD    = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_NEW       = 3'd3;
  localparam logic [2:0] ST_NEW_NOINIT = 3'd4;
  localparam logic [2:0] ST_IGNORED   = 3'd5;

  typedef enum logic [2:0] {
    REG_ENABLED   = 3'd0,
    REG_REPEAT    = 3'd1,
    REG_TIMEOUT   = 3'd2,
    REG_INITIAL   = 3'd3,
    REG_GROUP     = 3'd4
  } reg_idx_e;

  typedef enum logic {
    ENG_IDLE,
    ENG_SCAN
  } eng_state_e;

  typedef struct packed {
    logic        enabled;
    logic [15:0] repeat_ms;
    logic [15:0] timeout_ms;
    logic [7:0]  initial_value;
    logic [17:0] heartbeat_group;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  addr;
    logic [7:0]  seq;
    logic        nonstd;
    logic        txok;
  } cmd_t;

  typedef struct packed {
    event_e      kind;
    logic [7:0]  addr;
    logic [7:0]  seq;
    logic [2:0]  status;
    logic        last;
  } result_t;

  function automatic logic [7:0] next_seq(input logic [7:0] v);
    logic [7:0] n;
    n = v + 8'd1;
    return (v >= SEQ_WRAP_LIMIT) ? 8'd0 : n;
  endfunction

endpackage

// File: rtl/hsm_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on hsm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "heartbeat_sequence_monitor_macros.svh"
module hsm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [55:0]   s_tdata,   // node_address, group_number, data_length, seq_value,
                                   // requested_rate_ms, tx_accepted, pad
  input  logic [1:0]    s_tuser,   // operation
  input  hsm_pkg::cfg_t cfg,
  input  logic          pop,
  output logic          cmd_valid,
  output hsm_pkg::cmd_t cmd
);
  import hsm_pkg::*;

  cmd_t             q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QLVL_W-1:0] level;
  logic             accept;
  logic             push;
  cmd_t             cls;
  logic [7:0]       in_addr;
  logic [17:0]      in_group;
  logic [3:0]       in_len;
  logic [7:0]       in_seq;
  logic [15:0]      in_rate;
  logic             in_txok;
  logic             grp_ok;

  assign in_addr  = s_tdata[7:0];
  assign in_group = s_tdata[25:8];
  assign in_len   = s_tdata[29:26];
  assign in_seq   = s_tdata[37:30];
  assign in_rate  = s_tdata[53:38];
  assign in_txok  = s_tdata[54];

  assign s_tready  = (level != QLVL_W'(QUEUE_DEPTH));
  assign accept    = s_tvalid && s_tready;
  assign cmd_valid = (level != '0);
  assign cmd       = q_mem[rd_ptr];
  assign grp_ok    = cfg.enabled && (in_group == cfg.heartbeat_group);

  always_comb begin
    cls.addr   = in_addr;
    cls.seq    = in_seq;
    cls.nonstd = (in_rate != cfg.repeat_ms);
    cls.txok   = in_txok;
    cls.kind   = CMD_TICK;
    push       = accept;
    case (op_e'(s_tuser))
      OP_RX:   cls.kind = (grp_ok && in_len != 4'd0) ? CMD_RX : CMD_RX_IGN;
      OP_TICK: cls.kind = CMD_TICK;
      OP_REQ:  cls.kind = grp_ok ? CMD_REQ : CMD_REQ_IGN;
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + QLVL_W'(push) - QLVL_W'(pop);
    end
  end

  `HSM_ASSERT(a_level_max, level <= QLVL_W'(QUEUE_DEPTH), "queue level beyond depth")
  `HSM_ASSERT_NEVER(a_pop_empty, pop && level == '0, "pop from empty queue")
  `HSM_ASSERT(a_level_step, push && !pop |=> level == $past(level) + 1'b1, "level lost a push")
endmodule

// File: rtl/hsm_engine.sv
// Back end: node table, millisecond clock, scan sequencer and result register.
// Depends on hsm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "heartbeat_sequence_monitor_macros.svh"
module hsm_engine (
  input  logic            clk,
  input  logic            rst,
  input  hsm_pkg::cfg_t   cfg,
  input  logic            cmd_valid,
  input  hsm_pkg::cmd_t   cmd,
  output logic            pop,
  output logic            res_valid,
  input  logic            res_ready,
  output hsm_pkg::result_t res
);
  import hsm_pkg::*;

  logic              slot_local   [MAX_TRACKED];
  logic [7:0]        slot_address [MAX_TRACKED];
  logic [31:0]       slot_time    [MAX_TRACKED];
  logic [7:0]        slot_seq     [MAX_TRACKED];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [31:0]       clock_ms;
  logic              scan_txok;
  eng_state_e        state;
  eng_state_e        state_next;

  logic [MAX_TRACKED-1:0] hit;
  logic              hit_any;
  logic [IDX_W-1:0]  hit_idx;
  logic              full;
  logic              out_free;
  logic              emit;
  result_t           emit_res;
  logic              act_upd;
  logic              act_add;
  logic              add_local;
  logic [7:0]        add_seq;
  logic              act_tick;
  logic              act_tx;
  logic              act_rm;
  logic              act_inc;
  logic [IDX_W-1:0]  sidx;
  logic [31:0]       elapsed;
  logic              due_tx;
  logic              due_to;
  logic [2:0]        rx_status;

  always_comb begin
    hit_idx = '0;
    for (int j = 0; j < MAX_TRACKED; j++) begin
      hit[j] = (CNT_W'(j) < count) && (slot_address[j] == cmd.addr);
    end
    for (int j = MAX_TRACKED - 1; j >= 0; j--) begin
      if (hit[j]) begin
        hit_idx = IDX_W'(j);
      end
    end
  end

  assign hit_any  = |hit;
  assign full     = (count >= CNT_W'(MAX_TRACKED));
  assign out_free = !res_valid || res_ready;
  assign sidx     = idx[IDX_W-1:0];
  assign elapsed  = clock_ms - slot_time[sidx];
  assign due_tx   = slot_local[sidx] && scan_txok && (elapsed >= {16'd0, cfg.repeat_ms});
  assign due_to   = !slot_local[sidx] && (elapsed >= {16'd0, cfg.timeout_ms});

  always_comb begin
    if (cmd.seq == slot_seq[hit_idx]) begin
      rx_status = ST_DUPLICATE;
    end else if (cmd.seq != next_seq(slot_seq[hit_idx])) begin
      rx_status = ST_INVALID;
    end else begin
      rx_status = ST_OK;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_res   = '{kind: EV_DONE, addr: 8'd0, seq: 8'd0, status: ST_OK, last: 1'b1};
    act_upd    = 1'b0;
    act_add    = 1'b0;
    add_local  = 1'b0;
    add_seq    = cmd.seq;
    act_tick   = 1'b0;
    act_tx     = 1'b0;
    act_rm     = 1'b0;
    act_inc    = 1'b0;
    case (state)
      ENG_IDLE: begin
        if (cmd_valid && out_free) begin
          pop = 1'b1;
          emit_res.addr = cmd.addr;
          case (cmd.kind)
            CMD_RX: begin
              emit = 1'b1;
              emit_res.kind = EV_RX;
              emit_res.seq  = cmd.seq;
              if (hit_any) begin
                act_upd = 1'b1;
                emit_res.status = rx_status;
              end else if (!full) begin
                act_add = 1'b1;
                emit_res.status = (cmd.seq == cfg.initial_value) ? ST_NEW : ST_NEW_NOINIT;
              end else begin
                emit_res.status = ST_IGNORED;
              end
            end
            CMD_RX_IGN: begin
              emit = 1'b1;
              emit_res.kind   = EV_RX;
              emit_res.seq    = cmd.seq;
              emit_res.status = ST_IGNORED;
            end
            CMD_REQ: begin
              emit = 1'b1;
              emit_res.kind   = EV_REPLY;
              emit_res.status = cmd.nonstd ? ST_NONSTD : ST_OK;
              act_add   = !hit_any && !full;
              add_local = 1'b1;
              add_seq   = cfg.initial_value;
            end
            CMD_REQ_IGN: begin
              emit = 1'b1;
              emit_res.kind   = EV_REPLY;
              emit_res.status = ST_IGNORED;
            end
            CMD_TICK: begin
              act_tick = 1'b1;
              emit_res.addr = 8'd0;
              if (cfg.enabled) begin
                state_next = ENG_SCAN;
              end else begin
                emit = 1'b1;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ENG_SCAN: begin
        if (out_free) begin
          if (idx >= count) begin
            emit       = 1'b1;
            state_next = ENG_IDLE;
          end else if (due_tx) begin
            emit = 1'b1;
            emit_res = '{kind: EV_TX, addr: slot_address[sidx], seq: slot_seq[sidx],
                         status: ST_OK, last: 1'b0};
            act_tx  = 1'b1;
            act_inc = 1'b1;
          end else if (due_to) begin
            emit = 1'b1;
            emit_res = '{kind: EV_TIMEOUT, addr: slot_address[sidx], seq: slot_seq[sidx],
                         status: ST_OK, last: 1'b0};
            act_rm = 1'b1;
          end else begin
            act_inc = 1'b1;
          end
        end
      end
      default: state_next = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ENG_IDLE;
      count     <= '0;
      idx       <= '0;
      clock_ms  <= '0;
      res_valid <= 1'b0;
      scan_txok <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (act_tick) begin
        clock_ms  <= clock_ms + 32'd1;
        scan_txok <= cmd.txok;
        idx       <= '0;
      end
      if (act_inc) begin
        idx <= idx + 1'b1;
      end
      if (act_add) begin
        count <= count + 1'b1;
      end
      if (act_rm) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= emit_res;
    end
    if (act_upd) begin
      slot_time[hit_idx] <= clock_ms;
      slot_seq[hit_idx]  <= cmd.seq;
    end
    if (act_add) begin
      slot_local[count[IDX_W-1:0]]   <= add_local;
      slot_address[count[IDX_W-1:0]] <= cmd.addr;
      slot_time[count[IDX_W-1:0]]    <= clock_ms;
      slot_seq[count[IDX_W-1:0]]     <= add_seq;
    end
    if (act_tx) begin
      slot_time[sidx] <= clock_ms;
      slot_seq[sidx]  <= next_seq(slot_seq[sidx]);
    end
    if (act_rm) begin
      for (int j = 0; j < MAX_TRACKED - 1; j++) begin
        if (CNT_W'(j) >= idx && CNT_W'(j + 1) < count) begin
          slot_local[j]   <= slot_local[j + 1];
          slot_address[j] <= slot_address[j + 1];
          slot_time[j]    <= slot_time[j + 1];
          slot_seq[j]     <= slot_seq[j + 1];
        end
      end
    end
  end

  `HSM_ASSERT(a_count_max, count <= CNT_W'(MAX_TRACKED), "table count beyond capacity")
  `HSM_ASSERT(a_scan_idx, state == ENG_SCAN |-> idx <= count, "scan index past table end")
  `HSM_ASSERT_NEVER(a_add_full, act_add && full, "node added to full table")
  `HSM_ASSERT(a_scan_pop, state == ENG_SCAN |-> !pop, "command taken during scan")
endmodule

// File: rtl/heartbeat_sequence_monitor.sv
// Top level of the heartbeat sequence monitor: configuration registers and stream ports.
// Depends on hsm_pkg, hsm_front and hsm_engine.
`timescale 1ns / 1ps
// A received frame or heartbeat request gives one result transaction; a tick starts a
// sequential scan that visits each tracked node in table order and closes with a
// scan-done result (with the monitor disabled, the tick gives the scan-done result alone).
// The engine takes no new command during the scan, and it stalls while the result
// register is still held by the consumer.
// Inputs are queued two deep ahead of the engine. Configuration writes are never stalled.
module heartbeat_sequence_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // node_address, group_number, data_length, seq_value,
                                 // requested_rate_ms, tx_accepted, pad
  input  logic [1:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // node_address_res, out_seq, status, pad
  output logic [2:0]  m_tuser,   // event_kind
  output logic        m_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);
  import hsm_pkg::*;

  cfg_t    cfg;
  logic    pop;
  logic    cmd_valid;
  cmd_t    cmd;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled         <= 1'b1;
      cfg.repeat_ms       <= 16'd100;
      cfg.timeout_ms      <= 16'd300;
      cfg.initial_value   <= 8'd251;
      cfg.heartbeat_group <= 18'd61668;
    end else if (cfg_valid) begin
      case (reg_idx_e'(cfg_index))
        REG_ENABLED: cfg.enabled         <= cfg_data[0];
        REG_REPEAT:  cfg.repeat_ms       <= cfg_data[15:0];
        REG_TIMEOUT: cfg.timeout_ms      <= cfg_data[15:0];
        REG_INITIAL: cfg.initial_value   <= cfg_data[7:0];
        REG_GROUP:   cfg.heartbeat_group <= cfg_data;
        default: ;
      endcase
    end
  end

  hsm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg       (cfg),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  hsm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {5'd0, res.status, res.seq, res.addr};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;
endmodule

// File: tb/heartbeat_sequence_monitor_tb.sv
// Testbench for the heartbeat sequence monitor: stream stimulus, register writes
// and a cycle-free model of the node table checked against every result transaction.
// Depends on hsm_pkg and heartbeat_sequence_monitor.
`timescale 1ns / 1ps
module heartbeat_sequence_monitor_tb;
  import hsm_pkg::*;

  typedef struct {
    op_e         op;
    logic [7:0]  addr;
    logic [17:0] group;
    logic [3:0]  len;
    logic [7:0]  seq;
    logic [15:0] rate;
    logic        txok;
  } hb_item_t;

  typedef struct {
    event_e     kind;
    logic [7:0] addr;
    logic [7:0] seq;
    logic [2:0] status;
    logic       last;
  } hb_event_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [17:0] cfg_data;

  heartbeat_sequence_monitor uut (.*);

  // node table shadow
  logic        tbl_enabled;
  logic [15:0] tbl_repeat;
  logic [15:0] tbl_timeout;
  logic [7:0]  tbl_initial;
  logic [17:0] tbl_group;
  logic [31:0] tbl_clock;
  logic        tbl_local [MAX_TRACKED];
  logic [7:0]  tbl_addr  [MAX_TRACKED];
  logic [31:0] tbl_time  [MAX_TRACKED];
  logic [7:0]  tbl_seq   [MAX_TRACKED];
  int          tbl_used;

  hb_item_t  pend_q[$];
  hb_event_t event_q[$];
  hb_item_t  cur_item;
  logic      in_fire;
  int        fails;
  int        stall_left;
  logic      stall_go;
  logic      stall_done;
  logic      no_idle;

  // generator view of the configuration and of the last value sent per address
  logic [15:0] gen_repeat;
  logic [17:0] gen_group;
  logic [7:0]  gen_initial;
  logic [7:0]  gen_hint [256];

  function automatic logic [7:0] seq_after(input logic [7:0] v);
    return (v >= 8'd250) ? 8'd0 : v + 8'd1;
  endfunction

  function automatic int find_node(input logic [7:0] a);
    for (int i = 0; i < tbl_used; i++)
      if (tbl_addr[i] == a) return i;
    return -1;
  endfunction

  task automatic push_event(input event_e k, input logic [7:0] a, input logic [7:0] s,
                            input logic [2:0] st, input logic lst);
    hb_event_t e;
    e.kind = k; e.addr = a; e.seq = s; e.status = st; e.last = lst;
    event_q.push_back(e);
  endtask

  task automatic add_node(input logic [7:0] a, input logic loc, input logic [7:0] s);
    if (tbl_used < MAX_TRACKED) begin
      tbl_local[tbl_used] = loc;
      tbl_addr[tbl_used]  = a;
      tbl_time[tbl_used]  = tbl_clock;
      tbl_seq[tbl_used]   = s;
      tbl_used++;
    end
  endtask

  task automatic predict_results(input hb_item_t it);
    int          s;
    int          i;
    logic [2:0]  st;
    logic [31:0] elapsed;
    st = ST_IGNORED;
    case (it.op)
      OP_RX: begin
        if (tbl_enabled && it.group == tbl_group && it.len != 0) begin
          s = find_node(it.addr);
          if (s >= 0) begin
            tbl_time[s] = tbl_clock;
            if (it.seq == tbl_seq[s]) st = ST_DUPLICATE;
            else if (it.seq != seq_after(tbl_seq[s])) st = ST_INVALID;
            else st = ST_OK;
            tbl_seq[s] = it.seq;
          end else if (tbl_used < MAX_TRACKED) begin
            st = (it.seq == tbl_initial) ? ST_NEW : ST_NEW_NOINIT;
            add_node(it.addr, 1'b0, it.seq);
          end
        end
        push_event(EV_RX, it.addr, it.seq, st, 1'b1);
      end
      OP_TICK: begin
        tbl_clock++;
        if (tbl_enabled) begin
          i = 0;
          while (i < tbl_used) begin
            elapsed = tbl_clock - tbl_time[i];
            if (tbl_local[i]) begin
              if (elapsed >= tbl_repeat && it.txok) begin
                push_event(EV_TX, tbl_addr[i], tbl_seq[i], ST_OK, 1'b0);
                tbl_time[i] = tbl_clock;
                tbl_seq[i]  = seq_after(tbl_seq[i]);
              end
              i++;
            end else if (elapsed >= tbl_timeout) begin
              push_event(EV_TIMEOUT, tbl_addr[i], tbl_seq[i], ST_OK, 1'b0);
              for (int j = i; j + 1 < tbl_used; j++) begin
                tbl_local[j] = tbl_local[j + 1];
                tbl_addr[j]  = tbl_addr[j + 1];
                tbl_time[j]  = tbl_time[j + 1];
                tbl_seq[j]   = tbl_seq[j + 1];
              end
              tbl_used--;
            end else begin
              i++;
            end
          end
        end
        push_event(EV_DONE, 8'd0, 8'd0, ST_OK, 1'b1);
      end
      OP_REQ: begin
        if (tbl_enabled && it.group == tbl_group) begin
          st = (it.rate != tbl_repeat) ? ST_NONSTD : ST_OK;
          if (find_node(it.addr) < 0) add_node(it.addr, 1'b1, tbl_initial);
        end
        push_event(EV_REPLY, it.addr, 8'd0, st, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fails++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // source side
  always @(posedge clk) begin
    in_fire <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) predict_results(cur_item);
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= OP_RX;
    end else if (!s_tvalid || in_fire) begin
      if (pend_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 25)) begin
        cur_item = pend_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= cur_item.op;
        s_tdata  <= {1'b0, cur_item.txok, cur_item.rate, cur_item.seq, cur_item.len,
                     cur_item.group, cur_item.addr};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // sink side
  always @(negedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_go && !stall_done) begin
      m_tready   <= 1'b0;
      stall_left <= 300;
      stall_done <= 1'b1;
    end else begin
      m_tready <= no_idle || ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk) begin
    hb_event_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (event_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction kind %0d", m_tuser));
      end else begin
        e = event_q.pop_front();
        if (m_tuser != e.kind)
          report_mismatch($sformatf("event_kind %0d, want %0d", m_tuser, e.kind));
        if (m_tdata[7:0] != e.addr)
          report_mismatch($sformatf("node_address %0d, want %0d", m_tdata[7:0], e.addr));
        if (m_tdata[15:8] != e.seq)
          report_mismatch($sformatf("out_seq %0d, want %0d", m_tdata[15:8], e.seq));
        if (m_tdata[18:16] != e.status)
          report_mismatch($sformatf("status %0d, want %0d", m_tdata[18:16], e.status));
        if (m_tlast != e.last)
          report_mismatch($sformatf("last %0d, want %0d", m_tlast, e.last));
      end
    end
  end

  task automatic queue_item(input op_e op, input logic [7:0] a, input logic [17:0] g,
                            input logic [3:0] l, input logic [7:0] s,
                            input logic [15:0] r, input logic tx);
    hb_item_t it;
    it.op = op; it.addr = a; it.group = g; it.len = l; it.seq = s; it.rate = r;
    it.txok = tx;
    pend_q.push_back(it);
  endtask

  task automatic queue_random(input int count);
    int          r;
    op_e         op;
    logic [7:0]  a;
    logic [7:0]  s;
    for (int n = 0; n < count; n++) begin
      r  = $urandom_range(0, 99);
      op = (r < 45) ? OP_RX : (r < 80) ? OP_TICK : (r < 97) ? OP_REQ : OP_NONE;
      a  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(40, 59));
      r  = $urandom_range(0, 99);
      s  = (r < 50) ? seq_after(gen_hint[a]) : (r < 65) ? gen_hint[a] :
           (r < 80) ? gen_initial : 8'($urandom_range(0, 255));
      if (op == OP_RX) gen_hint[a] = s;
      queue_item(op, a,
                 ($urandom_range(0, 9) == 0) ? 18'($urandom_range(0, 262143)) : gen_group,
                 ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 8)), s,
                 ($urandom_range(0, 1) == 0) ? gen_repeat : 16'($urandom_range(0, 65535)),
                 $urandom_range(0, 4) != 0);
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [17:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLED: tbl_enabled = v[0];
      REG_REPEAT:  begin tbl_repeat  = v[15:0]; gen_repeat  = v[15:0]; end
      REG_TIMEOUT: tbl_timeout = v[15:0];
      REG_INITIAL: begin tbl_initial = v[7:0];  gen_initial = v[7:0];  end
      REG_GROUP:   begin tbl_group   = v;       gen_group   = v;       end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    do @(posedge clk); while (pend_q.size() > 0 || s_tvalid || event_q.size() > 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_all(input logic en, input logic [15:0] rep, input logic [15:0] tmo,
                         input logic [7:0] ini, input logic [17:0] grp);
    write_reg(REG_ENABLED, 18'(en));
    write_reg(REG_REPEAT, 18'(rep));
    write_reg(REG_TIMEOUT, 18'(tmo));
    write_reg(REG_INITIAL, 18'(ini));
    write_reg(REG_GROUP, grp);
  endtask

  initial begin
    fails = 0; stall_go = 1'b0; no_idle = 1'b0; in_fire = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_ENABLED; cfg_data = '0;
    tbl_enabled = 1'b1; tbl_repeat = 16'd100; tbl_timeout = 16'd300;
    tbl_initial = 8'd251; tbl_group = 18'd61668; tbl_clock = '0; tbl_used = 0;
    gen_repeat = 16'd100; gen_group = 18'd61668; gen_initial = 8'd251;
    foreach (gen_hint[k]) gen_hint[k] = 8'd0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    queue_item(OP_RX, 8'd5, 18'h3FFFF, 4'd1, 8'd1, 16'd0, 1'b0);
    queue_item(OP_RX, 8'd5, 18'd61668, 4'd0, 8'd1, 16'd0, 1'b0);
    queue_item(OP_RX, 8'd0, 18'd61668, 4'd1, 8'd251, 16'd0, 1'b0);
    queue_item(OP_RX, 8'd255, 18'd61668, 4'd8, 8'd7, 16'hFFFF, 1'b1);
    queue_item(OP_RX, 8'd0, 18'd61668, 4'd1, 8'd251, 16'd0, 1'b0);
    queue_item(OP_RX, 8'd0, 18'd61668, 4'd1, 8'd0, 16'd0, 1'b0);
    queue_item(OP_RX, 8'd0, 18'd61668, 4'd1, 8'd9, 16'd0, 1'b0);
    queue_item(OP_RX, 8'd255, 18'd61668, 4'd2, 8'd250, 16'd0, 1'b0);
    queue_item(OP_RX, 8'd255, 18'd61668, 4'd2, 8'd0, 16'd0, 1'b0);
    queue_item(OP_REQ, 8'h80, 18'd61668, 4'd0, 8'd0, 16'd100, 1'b0);
    queue_item(OP_REQ, 8'h81, 18'd61668, 4'd0, 8'd0, 16'hFFFF, 1'b0);
    queue_item(OP_REQ, 8'd0, 18'd61668, 4'd0, 8'd0, 16'd100, 1'b0);
    queue_item(OP_REQ, 8'h82, 18'd0, 4'd0, 8'd0, 16'd100, 1'b0);
    queue_item(OP_NONE, 8'hFF, 18'h3FFFF, 4'hF, 8'hFF, 16'hFFFF, 1'b1);
    queue_item(OP_TICK, 8'd0, 18'd0, 4'd0, 8'd0, 16'd0, 1'b0);
    queue_item(OP_TICK, 8'd0, 18'd0, 4'd0, 8'd0, 16'd0, 1'b1);
    for (int k = 0; k < 13; k++)
      queue_item(OP_RX, 8'(16 + k), 18'd61668, 4'd1, 8'd251, 16'd0, 1'b0);
    queue_item(OP_REQ, 8'd200, 18'd61668, 4'd0, 8'd0, 16'd100, 1'b0);
    queue_item(OP_TICK, 8'd0, 18'd0, 4'd0, 8'd0, 16'd0, 1'b1);
    drain();

    write_reg(REG_ENABLED, 18'd0);
    queue_item(OP_RX, 8'd0, 18'd61668, 4'd1, 8'd1, 16'd0, 1'b0);
    queue_item(OP_REQ, 8'd9, 18'd61668, 4'd0, 8'd0, 16'd100, 1'b0);
    queue_item(OP_TICK, 8'd0, 18'd0, 4'd0, 8'd0, 16'd0, 1'b1);
    drain();

    set_all(1'b1, 16'd1, 16'd1, 8'd0, 18'h3FFFF);
    stall_go = 1'b1;
    queue_random(30);
    drain();

    set_all(1'b1, 16'hFFFF, 16'hFFFF, 8'd255, 18'd0);
    queue_random(20);
    drain();

    set_all(1'b1, 16'd4, 16'd25, 8'd251, 18'd61668);
    queue_random(33);
    no_idle = 1'b1;
    queue_random(33);
    drain();
    no_idle = 1'b0;

    if (fails == 0) begin
      $display("heartbeat_sequence_monitor_tb OK");
    end else begin
      $display("heartbeat_sequence_monitor_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("heartbeat_sequence_monitor_tb NOT OK");
    $finish;
  end

endmodule
